// File: hdl/hca_pkg.sv
// ----------------------------------------------------------------------------
// hca_pkg
// Shared types and constants for the hybrid cellular automaton attractor
// analysis block.
// ----------------------------------------------------------------------------
package hca_pkg;

  localparam int CELLS  = 8;
  localparam int NST    = 1 << CELLS;
  localparam int STAT_W = 9;

  typedef logic [CELLS-1:0] state_t;
  typedef logic [CELLS:0]   len_t;
  typedef logic [STAT_W-1:0] stat_t;

  typedef struct packed {
    logic [7:0] cell7_rule;
    logic [7:0] cell6_rule;
    logic [7:0] cell5_rule;
    logic [7:0] cell4_rule;
    logic [7:0] cell3_rule;
    logic [7:0] cell2_rule;
    logic [7:0] cell1_rule;
    logic [7:0] cell0_rule;
  } in_word_t;

  typedef struct packed {
    logic [8:0] attractor_count;
    logic [8:0] point_attractor_count;
    logic [7:0] cyclic_attractor_count;
    logic [8:0] cycle_length_sum;
    logic [8:0] longest_cycle;
    logic [7:0] longest_chain;
    logic       is_reversible;
  } out_word_t;

endpackage

// File: hdl/hca_lane.sv
// ----------------------------------------------------------------------------
// hca_lane
// One cell lane: picks the rule bit addressed by left, mid and right.
// ----------------------------------------------------------------------------
module hca_lane import hca_pkg::*; (
  input  logic [7:0] rule,
  input  logic       left,
  input  logic       mid,
  input  logic       right,
  output logic       nxt
);

  assign nxt = rule[{left, mid, right}];

endmodule

// File: hdl/hca_next.sv
// ----------------------------------------------------------------------------
// hca_next
// Successor of one state: one lane per cell, bits merged into the next state
// with zero beyond both ends.
// ----------------------------------------------------------------------------
module hca_next import hca_pkg::*; (
  input  logic [CELLS-1:0][7:0] rules,
  input  state_t                cur,
  output state_t                nxt
);

  logic [CELLS+1:0] padded;

  assign padded = {1'b0, cur, 1'b0};

  for (genvar i = 0; i < CELLS; i++) begin : g_lane
    hca_lane u_lane (
      .rule  (rules[i]),
      .left  (padded[i]),
      .mid   (padded[i+1]),
      .right (padded[i+2]),
      .nxt   (nxt[i])
    );
  end

endmodule

// File: hdl/hybrid_ca_attractor_analysis.sv
// ----------------------------------------------------------------------------
// hybrid_ca_attractor_analysis
// Builds the successor table of a null-boundary hybrid automaton, walks the
// state graph and reports cycle and transient statistics.
//
//   channel | ports                          | word
//   input   | in_valid, in_stall, in_data    | in_word_t (one rule per cell)
//   output  | out_valid, out_stall, out_data | out_word_t (statistics)
//
// A job accepts the rule word and fills the successor table, then walks each
// new state and traces each cycle state, and closes the path of every start
// state.
// The walk is bound by the single read port of the successor memory.
// Reset is synchronous; it clears control and the result valid.
// A new word is taken while a result still waits on out_stall.
// ----------------------------------------------------------------------------
module hybrid_ca_attractor_analysis import hca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_WALK, S_WAIT, S_LOOK, S_LOOK2, S_CYC, S_CYCW, S_FIN, S_DONE
  } st_t;

  st_t                  st_r;
  logic [CELLS-1:0][7:0] rules_r;
  logic [7:0]           rules_all [8];
  logic [NST-1:0]       seen_r;
  state_t               cnt_r, s_r, cur_r, c_r, cyc0_r, chain_r, stepx_r;
  len_t                 steps_r, len_r, chain_sum;
  stat_t                attr_r, point_r, sum_r, maxcyc_r;
  state_t               maxch_r;
  out_word_t            out_r;
  logic                 out_valid_r;
  state_t               nxt_s;

  state_t succ_mem  [NST];
  state_t own_mem   [NST];
  state_t step_mem  [NST];
  state_t chain_mem [NST];
  state_t succ_q, own_q, step_q, chq;
  state_t succ_addr;

  assign rules_all = '{in_data.cell0_rule, in_data.cell1_rule, in_data.cell2_rule,
                       in_data.cell3_rule, in_data.cell4_rule, in_data.cell5_rule,
                       in_data.cell6_rule, in_data.cell7_rule};

  hca_next u_next (
    .rules (rules_r),
    .cur   (cnt_r),
    .nxt   (nxt_s)
  );

  assign succ_addr = (st_r == S_CYC) ? c_r : cur_r;
  assign chain_sum = steps_r + len_t'(chq) - len_t'(stepx_r);

  always_ff @(posedge clk) begin
    if (st_r == S_FILL) succ_mem[cnt_r] <= nxt_s;
    if (st_r == S_WALK && !seen_r[cur_r]) begin
      own_mem[cur_r]  <= s_r;
      step_mem[cur_r] <= steps_r[CELLS-1:0];
    end
    if (st_r == S_FIN) chain_mem[s_r] <= chain_r;
    succ_q <= succ_mem[succ_addr];
    own_q  <= own_mem[cur_r];
    step_q <= step_mem[cur_r];
    chq    <= chain_mem[own_q];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (st_r == S_DONE) begin
        if (!out_valid_r || !out_stall) out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: if (in_valid) begin
          for (int i = 0; i < CELLS; i++) rules_r[i] <= rules_all[i];
          seen_r   <= '0;
          cnt_r    <= '0;
          attr_r   <= '0;
          point_r  <= '0;
          sum_r    <= '0;
          maxcyc_r <= '0;
          maxch_r  <= '0;
          st_r     <= S_FILL;
        end
        S_FILL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            s_r     <= '0;
            cur_r   <= '0;
            steps_r <= '0;
            st_r    <= S_WALK;
          end
        end
        S_WALK: begin
          if (!seen_r[cur_r]) begin
            seen_r[cur_r] <= 1'b1;
            st_r <= S_WAIT;
          end else begin
            st_r <= S_LOOK;
          end
        end
        S_WAIT: begin
          cur_r   <= succ_q;
          steps_r <= steps_r + 1'b1;
          st_r    <= S_WALK;
        end
        S_LOOK: begin
          if (own_q == s_r) begin
            chain_r <= step_q;
            cyc0_r  <= cur_r;
            c_r     <= cur_r;
            len_r   <= '0;
            st_r    <= S_CYC;
          end else begin
            stepx_r <= step_q;
            st_r    <= S_LOOK2;
          end
        end
        S_LOOK2: begin
          if (stepx_r >= chq) begin
            chain_r <= steps_r[CELLS-1:0];
          end else begin
            chain_r <= chain_sum[CELLS-1:0];
          end
          st_r <= S_FIN;
        end
        S_CYC: begin
          len_r <= len_r + 1'b1;
          st_r  <= S_CYCW;
        end
        S_CYCW: begin
          c_r <= succ_q;
          if (succ_q == cyc0_r) begin
            attr_r <= attr_r + 1'b1;
            if (len_r == len_t'(1)) point_r <= point_r + 1'b1;
            sum_r <= sum_r + stat_t'(len_r);
            if (stat_t'(len_r) > maxcyc_r) maxcyc_r <= stat_t'(len_r);
            st_r <= S_FIN;
          end else begin
            st_r <= S_CYC;
          end
        end
        S_FIN: begin
          if (chain_r > maxch_r) maxch_r <= chain_r;
          if (s_r == '1) begin
            st_r <= S_DONE;
          end else begin
            s_r     <= s_r + 1'b1;
            cur_r   <= s_r + 1'b1;
            steps_r <= '0;
            st_r    <= S_WALK;
          end
        end
        S_DONE: if (!out_valid_r || !out_stall) begin
          out_r.attractor_count        <= attr_r;
          out_r.point_attractor_count  <= point_r;
          out_r.cyclic_attractor_count <= 8'(attr_r - point_r);
          out_r.cycle_length_sum       <= sum_r;
          out_r.longest_cycle          <= maxcyc_r;
          out_r.longest_chain          <= 8'(maxch_r);
          out_r.is_reversible          <= (maxch_r == '0);
          st_r        <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives rule words into the hybrid automaton attractor analysis block and
// checks each statistics word against fixed expected values or a behavioral
// model of the state graph walk. A directed table comes first, then random
// jobs with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import hca_pkg::*;

  localparam int  RANDOM_JOBS = 560;
  localparam int  DRAIN_WAIT  = 4000;
  localparam longint CYCLE_LIMIT = 64'd12000000;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t stats;
  } job_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  out_word_t pending_stats[$];
  int        mismatches;
  longint    cycle_count;
  job_row_t  job_table[$];

  hybrid_ca_attractor_analysis dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_word_t analyze_rules(in_word_t w);
    logic [7:0] rule [8];
    int         succ [256];
    bit         on_cycle [256];
    int         hits [256];
    int         attr, point, len_sum, max_cyc, max_chain;
    int         s, x, k, len, i, l, m, r, nx;
    bit         bij;
    out_word_t  o;
    rule[0] = w.cell0_rule; rule[1] = w.cell1_rule;
    rule[2] = w.cell2_rule; rule[3] = w.cell3_rule;
    rule[4] = w.cell4_rule; rule[5] = w.cell5_rule;
    rule[6] = w.cell6_rule; rule[7] = w.cell7_rule;
    for (s = 0; s < NST; s++) begin
      hits[s] = 0;
      on_cycle[s] = 1'b0;
    end
    for (s = 0; s < NST; s++) begin
      nx = 0;
      for (i = 0; i < CELLS; i++) begin
        l = (i == 0) ? 0 : ((s >> (i - 1)) & 1);
        m = (s >> i) & 1;
        r = (i == CELLS - 1) ? 0 : ((s >> (i + 1)) & 1);
        nx |= ((rule[i] >> (l * 4 + m * 2 + r)) & 1) << i;
      end
      succ[s] = nx;
      hits[nx]++;
    end
    bij = 1'b1;
    for (s = 0; s < NST; s++)
      if (hits[s] != 1) bij = 1'b0;
    attr = 0; point = 0; len_sum = 0; max_cyc = 0; max_chain = 0;
    for (s = 0; s < NST; s++) begin
      x = s;
      for (k = 0; k < NST; k++) x = succ[x];
      if (!on_cycle[x]) begin
        len = 0;
        k = x;
        do begin
          on_cycle[k] = 1'b1;
          len++;
          k = succ[k];
        end while (k != x);
        attr++;
        if (len == 1) point++;
        len_sum += len;
        if (len > max_cyc) max_cyc = len;
      end
    end
    for (s = 0; s < NST; s++) begin
      x = s;
      len = 0;
      while (!on_cycle[x] && len < NST) begin
        x = succ[x];
        len++;
      end
      if (len > max_chain) max_chain = len;
    end
    o.attractor_count        = attr[8:0];
    o.point_attractor_count  = point[8:0];
    o.cyclic_attractor_count = 8'(attr - point);
    o.cycle_length_sum       = len_sum[8:0];
    o.longest_cycle          = max_cyc[8:0];
    o.longest_chain          = max_chain[7:0];
    o.is_reversible          = bij;
    return o;
  endfunction

  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  function automatic in_word_t uniform_rules(logic [7:0] r);
    return {r, r, r, r, r, r, r, r};
  endfunction

  function automatic in_word_t random_job();
    logic [7:0] pool [8];
    in_word_t   w;
    int         pick, i;
    pool = '{8'd204, 8'd51, 8'd90, 8'd150, 8'd60, 8'd102, 8'd170, 8'd240};
    pick = $urandom_range(0, 99);
    w = {$urandom, $urandom};
    if (pick < 25) begin
      for (i = 0; i < 8; i++) w[i*8 +: 8] = pool[$urandom_range(0, 7)];
    end else if (pick < 35) begin
      for (i = 0; i < 8; i++)
        if ($urandom_range(0, 1)) w[i*8 +: 8] = pool[$urandom_range(0, 7)];
    end else if (pick < 40) begin
      w = uniform_rules($urandom_range(0, 255));
    end
    return w;
  endfunction

  task automatic add_row(in_word_t w, bit typed, out_word_t s);
    job_row_t row;
    row.word  = w;
    row.typed = typed;
    row.stats = s;
    job_table = {job_table, row};
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_job(in_word_t w, out_word_t stats, bit lead);
    int gap;
    gap = gap_cycles();
    if (gap > 0 && !lead) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    pending_stats = {pending_stats, stats};
  endtask

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int hold;
    out_word_t want;
    hold = 0;
    mismatches = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_stats.size() == 0) begin
          $display("%0t: unexpected word expected none actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = pending_stats.pop_front();
          check_field("attractor_count", want.attractor_count, out_data.attractor_count);
          check_field("point_attractor_count", want.point_attractor_count,
                      out_data.point_attractor_count);
          check_field("cyclic_attractor_count", want.cyclic_attractor_count,
                      out_data.cyclic_attractor_count);
          check_field("cycle_length_sum", want.cycle_length_sum,
                      out_data.cycle_length_sum);
          check_field("longest_cycle", want.longest_cycle, out_data.longest_cycle);
          check_field("longest_chain", want.longest_chain, out_data.longest_chain);
          check_field("is_reversible", want.is_reversible, out_data.is_reversible);
        end
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        hold = gap_cycles();
        out_stall <= (hold > 0);
      end
    end
  end

  initial begin
    int        i;
    in_word_t  w;
    out_word_t none;
    none = '0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    add_row(uniform_rules(8'd0),   1'b1, {9'd1, 9'd1, 8'd0, 9'd1, 9'd1, 8'd1, 1'b0});
    add_row(uniform_rules(8'd255), 1'b1, {9'd1, 9'd1, 8'd0, 9'd1, 9'd1, 8'd1, 1'b0});
    add_row(uniform_rules(8'd204), 1'b1,
            {9'd256, 9'd256, 8'd0, 9'd256, 9'd1, 8'd0, 1'b1});
    add_row(uniform_rules(8'd51),  1'b1,
            {9'd128, 9'd0, 8'd128, 9'd256, 9'd2, 8'd0, 1'b1});
    add_row(uniform_rules(8'd90),  1'b0, none);
    add_row(uniform_rules(8'd150), 1'b0, none);
    add_row(uniform_rules(8'd170), 1'b0, none);
    add_row(uniform_rules(8'd240), 1'b0, none);
    add_row(uniform_rules(8'd60),  1'b0, none);
    add_row(uniform_rules(8'd30),  1'b0, none);
    add_row(uniform_rules(8'd110), 1'b0, none);
    add_row(64'h00FF_00FF_00FF_00FF, 1'b0, none);
    add_row(64'hFF00_FF00_FF00_FF00, 1'b0, none);
    add_row(64'hCCCC_CCCC_CCCC_CC33, 1'b0, none);
    add_row(64'h33CC_CCCC_CCCC_CCCC, 1'b0, none);
    add_row(64'h5A96_5A96_5A96_5A96, 1'b0, none);
    add_row(64'h96CC_3366_F0AA_5A3C, 1'b0, none);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, none);
    add_row(64'h5555_5555_5555_5555, 1'b0, none);
    add_row(64'h0102_0408_1020_4080, 1'b0, none);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < job_table.size(); i++)
      send_job(job_table[i].word,
               job_table[i].typed ? job_table[i].stats : analyze_rules(job_table[i].word),
               i == 0);

    for (i = 0; i < RANDOM_JOBS; i++) begin
      if (i == RANDOM_JOBS / 2) begin
        in_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
      end
      w = random_job();
      send_job(w, analyze_rules(w), i == RANDOM_JOBS / 2);
    end
    in_valid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/hca_pkg.sv
hdl/hca_lane.sv
hdl/hca_next.sv
hdl/hybrid_ca_attractor_analysis.sv
verif/testbench.sv
